// ----- rtl/core/sfr_pkg.sv -----
// sfr_pkg: shared types and constants for the sensor frame receiver
// no dependencies
`default_nettype none

package sfr_pkg;

    localparam logic [7:0]  WAKE_RESET   = 8'd85;
    localparam logic [7:0]  UPDATE_RESET = 8'd80;
    localparam logic [7:0]  REPLY_RESET  = 8'd81;
    localparam logic [15:0] ANGLE_LIMIT  = 16'd3600;
    localparam logic [2:0]  UPDATE_LEN   = 3'd6;
    localparam logic [2:0]  REPLY_LEN    = 3'd1;
    localparam int          QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        CFG_WAKE   = 2'd0,
        CFG_UPDATE = 2'd1,
        CFG_REPLY  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_REPLY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic {
        FRAME_UPDATE = 1'b0,
        FRAME_REPLY  = 1'b1
    } frame_t;

    // update data: x in [47:32], y in [31:16], angle in [15:0]
    // reply data: flag number in [7:0]; clear data: mask in [7:0]
    typedef struct packed {
        op_t         op;
        logic [47:0] data;
    } entry_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/sensor_frame_receiver_top.sv -----
// a completing byte is written into the queue, then the state update registers the result and raises m_tvalid
// throughput: 1 byte per cycle while s_tready is high, set by the two-entry queue and the output register
// a stalled result port fills the queue, then s_tready drops until space frees
// reset: aresetn synchronous active low, clears parser, queue and held state, restores codes
// sensor_frame_receiver_top: parser, queue and state update; depends on sfr_pkg,
// sfr_front, sfr_queue, sfr_back
`default_nettype none

module sensor_frame_receiver_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_value
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // pos_x, pos_y, heading, position_valid, ack_flags
    output logic             m_tuser,   // frame_type
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    sfr_pkg::entry_t        push_entry, head;
    sfr_pkg::queue_status_t q_status;
    logic                   push, pop, accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;

    sfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .in_kind    (s_tuser),
        .in_byte    (s_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    sfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_status.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= 2'(sfr_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_status.full)
        else $error("input stalled with queue space left");

    a_valid_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48]) |-> (m_tdata[47:32] < sfr_pkg::ANGLE_LIMIT))
        else $error("valid position with out-of-range heading");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("transaction pushed into full queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sfr_front.sv -----
// sfr_front: config registers and frame parser, emits completed frames and clears
// depends on sfr_pkg
`default_nettype none

module sfr_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              accept,
    input  wire logic              in_kind,
    input  wire logic [7:0]        in_byte,
    output logic                   push,
    output sfr_pkg::entry_t        push_entry
);

    typedef enum logic [1:0] {
        WAIT_WAKE = 2'd0,
        GET_CMD   = 2'd1,
        GET_LEN   = 2'd2,
        GET_DATA  = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        cmd_reg, cmd_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  wake_reg, update_reg, reply_reg;
    logic [7:0]  payload_reg [0:4];
    logic        pay_we;
    logic [2:0]  cur_len;
    logic [2:0]  count_inc;

    assign cur_len   = cmd_reg ? sfr_pkg::REPLY_LEN : sfr_pkg::UPDATE_LEN;
    assign count_inc = count_reg + 3'd1;

    always_comb begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        pay_we          = 1'b0;
        push            = 1'b0;
        push_entry.op   = sfr_pkg::OP_CLEAR;
        push_entry.data = {40'd0, in_byte};
        if (accept) begin
            if (in_kind) begin
                push = 1'b1;
            end else begin
                unique case (phase_reg)
                    WAIT_WAKE: begin
                        if (in_byte == wake_reg) begin
                            phase_next = GET_CMD;
                            count_next = 3'd0;
                        end
                    end
                    GET_CMD: begin
                        if (in_byte == update_reg) begin
                            cmd_next   = 1'b0;
                            phase_next = GET_LEN;
                        end else if (in_byte == reply_reg) begin
                            cmd_next   = 1'b1;
                            phase_next = GET_LEN;
                        end else begin
                            phase_next = WAIT_WAKE;
                        end
                    end
                    GET_LEN: begin
                        phase_next = (in_byte == {5'd0, cur_len}) ? GET_DATA : WAIT_WAKE;
                        count_next = 3'd0;
                    end
                    GET_DATA: begin
                        pay_we     = (count_reg < 3'd5);
                        count_next = count_inc;
                        if (count_inc == cur_len) begin
                            phase_next = WAIT_WAKE;
                            count_next = 3'd0;
                            push       = 1'b1;
                            if (cmd_reg) begin
                                push_entry.op = sfr_pkg::OP_REPLY;
                            end else begin
                                push_entry.op   = sfr_pkg::OP_UPDATE;
                                push_entry.data = {payload_reg[0], payload_reg[1],
                                                   payload_reg[2], payload_reg[3],
                                                   payload_reg[4], in_byte};
                            end
                        end
                    end
                    default: phase_next = WAIT_WAKE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= WAIT_WAKE;
            cmd_reg    <= 1'b0;
            count_reg  <= 3'd0;
            wake_reg   <= sfr_pkg::WAKE_RESET;
            update_reg <= sfr_pkg::UPDATE_RESET;
            reply_reg  <= sfr_pkg::REPLY_RESET;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                unique case (sfr_pkg::cfg_idx_t'(cfg_index))
                    sfr_pkg::CFG_WAKE:   wake_reg   <= cfg_data;
                    sfr_pkg::CFG_UPDATE: update_reg <= cfg_data;
                    sfr_pkg::CFG_REPLY:  reply_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pay_we) begin
            payload_reg[count_reg] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sfr_queue.sv -----
// sfr_queue: two-entry queue between parser and state update
// depends on sfr_pkg
`default_nettype none

module sfr_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sfr_pkg::entry_t   push_entry,
    input  wire logic              pop,
    output sfr_pkg::entry_t        head,
    output sfr_pkg::queue_status_t status
);

    sfr_pkg::entry_t mem_reg [0:sfr_pkg::QUEUE_DEPTH-1];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == 2'(sfr_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sfr_back.sv -----
// sfr_back: held position and flag state, result output register
// depends on sfr_pkg
`default_nettype none

module sfr_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sfr_pkg::entry_t   head,
    input  wire logic              q_empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic                   m_tuser,
    output logic [63:0]            m_tdata
);

    logic [15:0] x_reg, y_reg, angle_reg;
    logic [15:0] x_next, y_next, angle_next;
    logic        vmark_reg, vmark_next;
    logic [7:0]  flags_reg, flags_next;
    logic        ovalid_reg, otype_reg, otype_next;
    logic [63:0] odata_reg;
    logic        out_free, emit;

    assign out_free = !ovalid_reg || m_tready;

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        angle_next = angle_reg;
        vmark_next = vmark_reg;
        flags_next = flags_reg;
        otype_next = sfr_pkg::FRAME_UPDATE;
        pop        = 1'b0;
        emit       = 1'b0;
        if (!q_empty) begin
            unique case (head.op)
                sfr_pkg::OP_CLEAR: begin
                    pop        = 1'b1;
                    flags_next = flags_reg & ~head.data[7:0];
                end
                sfr_pkg::OP_UPDATE: begin
                    if (out_free) begin
                        pop  = 1'b1;
                        emit = 1'b1;
                        if (head.data[15:0] < sfr_pkg::ANGLE_LIMIT) begin
                            x_next     = head.data[47:32];
                            y_next     = head.data[31:16];
                            angle_next = head.data[15:0];
                            vmark_next = 1'b1;
                        end else begin
                            vmark_next = 1'b0;
                        end
                    end
                end
                sfr_pkg::OP_REPLY: begin
                    if (out_free) begin
                        pop        = 1'b1;
                        emit       = 1'b1;
                        otype_next = sfr_pkg::FRAME_REPLY;
                        if (head.data[7:3] == 5'd0) begin
                            flags_next = flags_reg | (8'd1 << head.data[2:0]);
                        end
                    end
                end
                default: pop = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg      <= 16'd0;
            y_reg      <= 16'd0;
            angle_reg  <= 16'd0;
            vmark_reg  <= 1'b0;
            flags_reg  <= 8'd0;
            ovalid_reg <= 1'b0;
        end else begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            angle_reg <= angle_next;
            vmark_reg <= vmark_next;
            flags_reg <= flags_next;
            if (emit) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            otype_reg <= otype_next;
            odata_reg <= {7'd0, flags_next, vmark_next, angle_next, y_next, x_next};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = otype_reg;
    assign m_tdata  = odata_reg;

endmodule

`default_nettype wire
